// ----- src/sspk_pkg.sv -----
// ----------------------------------------------------------------------------
// sspk_pkg
// Types and constants shared by the sync sequence sliding peak search.
// ----------------------------------------------------------------------------
`default_nettype none

package sspk_pkg;

  localparam int unsigned MaxRefLen   = 128;
  localparam int unsigned RefAddrBits = 7;
  localparam int unsigned MaxFrameLen = 65536;
  localparam int unsigned CountBits   = 17;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned MetricBits  = 38;
  localparam int unsigned OffsetBits  = 16;
  localparam int unsigned LenBits     = 8;
  localparam int unsigned ProdBits    = 2 * SampleBits;
  localparam int unsigned MagBits     = ProdBits - 1;
  localparam int unsigned RadBits     = 2 * MagBits;
  localparam int unsigned RootBits    = MagBits;

  localparam logic [LenBits-1:0] LenReset = LenBits'(MaxRefLen);

  localparam logic ActionRefLoad = 1'b0;
  localparam logic ActionData    = 1'b1;

  typedef struct packed {
    logic                         action;
    logic [RefAddrBits-1:0]       ref_index;
    logic signed [SampleBits-1:0] in_phase;
    logic signed [SampleBits-1:0] quadrature;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic                  peak_found;
    logic [OffsetBits-1:0] peak_offset;
    logic [MetricBits-1:0] peak_metric;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- src/sync_sequence_sliding_peak_search.sv -----
// ----------------------------------------------------------------------------
// sync_sequence_sliding_peak_search
// Sliding window peak search of a stored sync sequence over a received frame.
// ----------------------------------------------------------------------------
//  channel  direction  payload                      handshake
//  in       input      sspk_pkg::in_t (in_item)     in_valid / in_ready
//  out      output     sspk_pkg::out_t (out_item)   out_valid / out_ready
//  cfg      input      reference_length (cfg_data)  cfg_valid / cfg_ready
//
//  A reference load or a data sample that closes no window starts no search.
//  A data sample that closes a window starts a search over length terms:
//  one window term is read per cycle from the sample and reference memories,
//  then passes two multiplier stages and a 31 stage square root pipeline.
//  A last sample then passes a finish state that loads the result register,
//  and waits there while a previous result has not been taken. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_sequence_sliding_peak_search (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire sspk_pkg::in_t                       in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output sspk_pkg::out_t                           out_item,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sspk_pkg::LenBits-1:0]        cfg_data
);

  localparam int unsigned AW = sspk_pkg::RefAddrBits;
  localparam int unsigned SW = sspk_pkg::SampleBits;
  localparam int unsigned LW = sspk_pkg::LenBits;
  localparam int unsigned CW = sspk_pkg::CountBits;
  localparam int unsigned MW = sspk_pkg::MetricBits;
  localparam int unsigned PW = sspk_pkg::ProdBits;
  localparam int unsigned GW = sspk_pkg::MagBits;
  localparam int unsigned RW = sspk_pkg::RadBits;
  localparam int unsigned OW = sspk_pkg::OffsetBits;

  sspk_pkg::state_t state, state_next;

  logic [LW-1:0] ref_len;
  logic [LW-1:0] len;
  logic [LW-1:0] len_eff;
  logic [CW-1:0] count;
  logic [CW-1:0] count_inc;
  logic [AW-1:0] wp;
  logic [AW-1:0] base;
  logic [LW-1:0] issue_cnt;
  logic [LW-1:0] acc_cnt;
  logic [MW-1:0] acc;
  logic [MW:0]   acc_sum;
  logic [OW-1:0] off_pend;
  logic          last_pend;
  logic [MW-1:0] best_metric;
  logic [OW-1:0] best_offset;
  logic          best_valid;

  logic          accept;
  logic          is_data;
  logic          counting;
  logic          eval;
  logic          issue;
  logic          done;
  logic          fin_load;

  logic [2*SW-1:0] ref_mem [sspk_pkg::MaxRefLen];
  logic [2*SW-1:0] win_mem [sspk_pkg::MaxRefLen];
  logic [2*SW-1:0] ref_rd;
  logic [2*SW-1:0] win_rd;

  logic                 v_b, v_c, v_d, v_e;
  logic signed [PW-1:0] prod_i, prod_q;
  logic [PW-1:0]        abs_i, abs_q;
  logic [RW-1:0]        sq_i, sq_q;
  logic [RW-1:0]        rad;
  logic                 root_valid;
  logic [GW-1:0]        root;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == sspk_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_data   = (in_item.action == sspk_pkg::ActionData);

  assign len_eff   = (ref_len == '0) ? LW'(1) :
                     (ref_len > LW'(sspk_pkg::MaxRefLen)) ? LW'(sspk_pkg::MaxRefLen) :
                     ref_len;
  assign counting  = (count < CW'(sspk_pkg::MaxFrameLen));
  assign count_inc = count + CW'(1);
  assign eval      = counting && (count_inc >= CW'(len_eff));

  assign issue     = (state == sspk_pkg::ST_RUN) && (issue_cnt != len);
  assign done      = (state == sspk_pkg::ST_RUN) && (acc_cnt == len);
  assign fin_load  = (state == sspk_pkg::ST_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) state <= sspk_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sspk_pkg::ST_IDLE: begin
        if (accept && is_data) begin
          if (eval)              state_next = sspk_pkg::ST_RUN;
          else if (in_item.last) state_next = sspk_pkg::ST_FIN;
        end
      end
      sspk_pkg::ST_RUN: begin
        if (done) state_next = last_pend ? sspk_pkg::ST_FIN : sspk_pkg::ST_IDLE;
      end
      sspk_pkg::ST_FIN: begin
        if (fin_load) state_next = sspk_pkg::ST_IDLE;
      end
      default: state_next = sspk_pkg::ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && !is_data) begin
      ref_mem[in_item.ref_index] <= {in_item.in_phase, in_item.quadrature};
    end
    if (accept && is_data) begin
      win_mem[wp] <= {in_item.in_phase, in_item.quadrature};
    end
    if (issue) begin
      ref_rd <= ref_mem[issue_cnt[AW-1:0]];
      win_rd <= win_mem[base + issue_cnt[AW-1:0]];
    end
  end

  // term pipeline
  always_ff @(posedge clk) begin
    prod_i <= $signed(win_rd[2*SW-1:SW]) * $signed(ref_rd[2*SW-1:SW]);
    prod_q <= $signed(win_rd[SW-1:0]) * $signed(ref_rd[SW-1:0]);
    sq_i   <= abs_i[GW-1:0] * abs_i[GW-1:0];
    sq_q   <= abs_q[GW-1:0] * abs_q[GW-1:0];
    rad    <= sq_i + sq_q;
  end

  assign abs_i   = prod_i[PW-1] ? PW'(-prod_i) : PW'(prod_i);
  assign abs_q   = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign acc_sum = {1'b0, acc} + (MW + 1)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      v_b <= issue;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  sspk_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_e),
    .radicand  (rad),
    .out_valid (root_valid),
    .root      (root)
  );

  // control and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len     <= sspk_pkg::LenReset;
      count       <= '0;
      wp          <= '0;
      best_metric <= '0;
      best_offset <= '0;
      best_valid  <= 1'b0;
      out_valid   <= 1'b0;
      issue_cnt   <= '0;
      acc_cnt     <= '0;
      acc         <= '0;
      last_pend   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) ref_len <= cfg_data;
      if (out_valid && out_ready && !fin_load) out_valid <= 1'b0;
      if (accept && is_data) begin
        wp        <= wp + AW'(1);
        last_pend <= in_item.last;
        len       <= len_eff;
        base      <= wp + AW'(1) - len_eff[AW-1:0];
        off_pend  <= OW'(count_inc - CW'(len_eff));
        issue_cnt <= '0;
        acc_cnt   <= '0;
        acc       <= '0;
        if (counting) count <= count_inc;
      end
      if (issue) issue_cnt <= issue_cnt + LW'(1);
      if (root_valid) begin
        acc     <= acc_sum[MW] ? '1 : acc_sum[MW-1:0];
        acc_cnt <= acc_cnt + LW'(1);
      end
      if (done && (acc > best_metric)) begin
        best_metric <= acc;
        best_offset <= off_pend;
        best_valid  <= 1'b1;
      end
      if (fin_load) begin
        out_valid            <= 1'b1;
        out_item.peak_found  <= best_valid;
        out_item.peak_offset <= best_offset;
        out_item.peak_metric <= best_metric;
        count                <= '0;
        best_metric          <= '0;
        best_offset          <= '0;
        best_valid           <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/sspk_sqrt.sv -----
// ----------------------------------------------------------------------------
// sspk_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sspk_sqrt (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [sspk_pkg::RadBits-1:0]      radicand,
  output logic                                   out_valid,
  output logic [sspk_pkg::RootBits-1:0]          root
);

  localparam int unsigned W      = sspk_pkg::RadBits;
  localparam int unsigned Stages = sspk_pkg::RootBits;

  logic [W-1:0] rem_q  [Stages];
  logic [W-1:0] root_q [Stages];
  logic         vld_q  [Stages];

  function automatic logic [2*W-1:0] sqrt_step(input logic [W-1:0] x,
                                               input logic [W-1:0] r,
                                               input int unsigned k);
    logic [W-1:0] b;
    logic [W-1:0] t;
    b = W'(1) << (W - 2 - 2 * k);
    t = r + b;
    if (x >= t) begin
      sqrt_step = {x - t, (r >> 1) + b};
    end else begin
      sqrt_step = {x, r >> 1};
    end
  endfunction

  always_ff @(posedge clk) begin
    {rem_q[0], root_q[0]} <= sqrt_step(radicand, '0, 0);
    for (int unsigned k = 1; k < Stages; k++) begin
      {rem_q[k], root_q[k]} <= sqrt_step(rem_q[k-1], root_q[k-1], k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int unsigned k = 0; k < Stages; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid;
      for (int unsigned k = 1; k < Stages; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  assign out_valid = vld_q[Stages-1];
  assign root      = root_q[Stages-1][sspk_pkg::RootBits-1:0];

endmodule

`default_nettype wire
